@@ rtl/asc_pkg.sv @@
package asc_pkg;

    localparam int OPCODE_W = 16;
    localparam int DATA_W   = 32;
    localparam int FLAGS_W  = 5;
    localparam int SIZE_W   = 2;
    localparam int STATUS_W = 2;

    localparam int FLAG_X = 4;
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_C = 0;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_LONG = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ILLEGAL_AN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNHANDLED  = 2'd2;

    localparam logic [3:0] GROUP_MOVEQ = 4'h7;
    localparam logic [3:0] GROUP_SUB   = 4'h9;
    localparam logic [3:0] GROUP_CMP   = 4'hB;
    localparam logic [3:0] GROUP_ADD   = 4'hD;

    localparam logic [2:0] OPMODE_ADDR_WORD = 3'b011;
    localparam logic [2:0] OPMODE_ADDR_LONG = 3'b111;
    localparam logic [2:0] MODE_AREG        = 3'b001;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   source_value;
        logic [DATA_W-1:0]   dest_value;
        logic [FLAGS_W-1:0]  flags_in;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   result;
        logic [SIZE_W-1:0]   result_size;
        logic                writes_result;
        logic                to_address_register;
        logic [FLAGS_W-1:0]  flags_out;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic              sub;
        logic              carry_in;
        logic [SIZE_W-1:0] size;
    } arith_ctl_t;

    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } nzvc_t;

endpackage

@@ rtl/asc_in_if.sv @@
interface asc_in_if;
    import asc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   source_value;
    logic [DATA_W-1:0]   dest_value;
    logic [FLAGS_W-1:0]  flags_in;

    modport source (
        output valid,
        output opcode,
        output source_value,
        output dest_value,
        output flags_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  source_value,
        input  dest_value,
        input  flags_in,
        output ready
    );

endinterface

@@ rtl/asc_out_if.sv @@
interface asc_out_if;
    import asc_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   result;
    logic [SIZE_W-1:0]   result_size;
    logic                writes_result;
    logic                to_address_register;
    logic [FLAGS_W-1:0]  flags_out;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid,
        output result,
        output result_size,
        output writes_result,
        output to_address_register,
        output flags_out,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  result,
        input  result_size,
        input  writes_result,
        input  to_address_register,
        input  flags_out,
        input  status,
        output ready
    );

endinterface

@@ rtl/asc_arith.sv @@
module asc_arith (
    input  asc_pkg::arith_ctl_t        ctl,
    input  logic [asc_pkg::DATA_W-1:0] d,
    input  logic [asc_pkg::DATA_W-1:0] s,
    output logic [asc_pkg::DATA_W-1:0] r,
    output asc_pkg::nzvc_t             flags
);
    import asc_pkg::*;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] dm;
    logic [DATA_W-1:0] sm;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] cvec;
    logic [DATA_W-1:0] vvec;
    logic [DATA_W-1:0] cin;

    always_comb
    begin
        case (ctl.size)
            SIZE_BYTE: mask = 32'h0000_00FF;
            SIZE_WORD: mask = 32'h0000_FFFF;
            default:   mask = 32'hFFFF_FFFF;
        endcase
        dm  = d & mask;
        sm  = s & mask;
        cin = {{(DATA_W-1){1'b0}}, ctl.carry_in};
        if (ctl.sub)
        begin
            sum  = dm - sm - cin;
            r    = sum & mask;
            cvec = (sm & ~dm) | (r & (~dm | sm));
            vvec = (sm ^ dm) & (r ^ dm);
        end
        else
        begin
            sum  = dm + sm + cin;
            r    = sum & mask;
            cvec = (sm & dm) | (~r & (sm | dm));
            vvec = (sm ^ r) & (dm ^ r);
        end
        flags.z = (r == '0);
        case (ctl.size)
            SIZE_BYTE:
            begin
                flags.n = r[7];
                flags.v = vvec[7];
                flags.c = cvec[7];
            end
            SIZE_WORD:
            begin
                flags.n = r[15];
                flags.v = vvec[15];
                flags.c = cvec[15];
            end
            default:
            begin
                flags.n = r[DATA_W-1];
                flags.v = vvec[DATA_W-1];
                flags.c = cvec[DATA_W-1];
            end
        endcase
    end

endmodule

@@ rtl/asc_exec.sv @@
module asc_exec (
    input  asc_pkg::in_item_t  item,
    output asc_pkg::out_item_t res
);
    import asc_pkg::*;

    logic [3:0]        group;
    logic [2:0]        opmode;
    logic [SIZE_W-1:0] sz;
    logic [2:0]        mode;
    logic              is_addr;
    logic              is_ext;
    logic [DATA_W-1:0] src_ext;
    logic [DATA_W-1:0] moveq_val;
    logic              x_in;
    arith_ctl_t        ctl;
    logic [DATA_W-1:0] ar;
    nzvc_t             af;

    assign group     = item.opcode[15:12];
    assign opmode    = item.opcode[8:6];
    assign sz        = item.opcode[7:6];
    assign mode      = item.opcode[5:3];
    assign x_in      = item.flags_in[FLAG_X];
    assign is_addr   = (opmode == OPMODE_ADDR_WORD) || (opmode == OPMODE_ADDR_LONG);
    assign is_ext    = (group != GROUP_CMP) && item.opcode[8] && (item.opcode[5:4] == 2'b00);
    assign moveq_val = {{(DATA_W-8){item.opcode[7]}}, item.opcode[7:0]};

    always_comb
    begin
        if (opmode == OPMODE_ADDR_WORD)
            src_ext = {{(DATA_W-16){item.source_value[15]}}, item.source_value[15:0]};
        else
            src_ext = item.source_value;
    end

    // one shared adder, operands chosen per form
    always_comb
    begin
        ctl.sub      = (group != GROUP_ADD);
        ctl.carry_in = !is_addr && is_ext && x_in;
        ctl.size     = is_addr ? SIZE_LONG : sz;
    end

    asc_arith u_arith (
        .ctl   (ctl),
        .d     (item.dest_value),
        .s     (src_ext),
        .r     (ar),
        .flags (af)
    );

    always_comb
    begin
        res.result              = '0;
        res.result_size         = SIZE_BYTE;
        res.writes_result       = 1'b0;
        res.to_address_register = 1'b0;
        res.flags_out           = item.flags_in;
        res.status              = STATUS_DONE;
        case (group)
            GROUP_MOVEQ:
            begin
                res.result        = moveq_val;
                res.result_size   = SIZE_LONG;
                res.writes_result = 1'b1;
                res.flags_out     = {x_in, moveq_val[DATA_W-1], moveq_val == '0, 2'b00};
            end
            GROUP_SUB, GROUP_CMP, GROUP_ADD:
            begin
                if (is_addr)
                begin
                    res.result_size = SIZE_LONG;
                    if (group == GROUP_CMP)
                    begin
                        res.flags_out = {x_in, af.n, af.z, af.v, af.c};
                    end
                    else
                    begin
                        res.result              = ar;
                        res.writes_result       = 1'b1;
                        res.to_address_register = 1'b1;
                    end
                end
                else if (group == GROUP_CMP && item.opcode[8])
                begin
                    // cmpm, otherwise eor
                    res.result_size = sz;
                    if (mode == MODE_AREG)
                        res.flags_out = {x_in, af.n, af.z, af.v, af.c};
                    else
                        res.status = STATUS_UNHANDLED;
                end
                else if (is_ext)
                begin
                    res.result        = ar;
                    res.result_size   = sz;
                    res.writes_result = 1'b1;
                    res.flags_out     = {af.c, af.n, af.z & item.flags_in[FLAG_Z], af.v, af.c};
                end
                else
                begin
                    res.result_size = sz;
                    if (sz == SIZE_BYTE && mode == MODE_AREG)
                    begin
                        res.status = STATUS_ILLEGAL_AN;
                    end
                    else if (group == GROUP_CMP)
                    begin
                        res.flags_out = {x_in, af.n, af.z, af.v, af.c};
                    end
                    else
                    begin
                        res.result        = ar;
                        res.writes_result = 1'b1;
                        res.flags_out     = {af.c, af.n, af.z, af.v, af.c};
                    end
                end
            end
            default:
            begin
                res.status = STATUS_UNHANDLED;
            end
        endcase
    end

endmodule

@@ rtl/add_sub_compare_alu_with_flags.sv @@
// Execute unit for the add, subtract, compare and moveq groups. Each beat on
// req carries an opcode, both fetched operands and the current XNZVC flags;
// one beat on rsp returns the sized result, write and address-register marks,
// new flags and a status. Inside, an item goes through an input register,
// one pass through the decoder and a single shared 32-bit adder, and a result
// register. A new beat is taken every cycle while rsp accepts; a result that
// waits on rsp holds req off only once the input register is also full.
module add_sub_compare_alu_with_flags (
    input logic      clk,
    input logic      rst_n,
    asc_in_if.sink   req,
    asc_out_if.source rsp
);
    import asc_pkg::*;

    logic      in_vld_reg;
    logic      in_vld_next;
    in_item_t  in_item_reg;
    logic      out_vld_reg;
    logic      out_vld_next;
    out_item_t out_item_reg;
    out_item_t exec_res;
    logic      out_free;
    logic      in_free;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign in_free   = !in_vld_reg || out_free;
    assign req.ready = in_free;

    assign in_vld_next  = in_free ? req.valid : in_vld_reg;
    assign out_vld_next = out_free ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && in_free)
        begin
            in_item_reg.opcode       <= req.opcode;
            in_item_reg.source_value <= req.source_value;
            in_item_reg.dest_value   <= req.dest_value;
            in_item_reg.flags_in     <= req.flags_in;
        end
        if (in_vld_reg && out_free)
            out_item_reg <= exec_res;
    end

    asc_exec u_exec (
        .item (in_item_reg),
        .res  (exec_res)
    );

    assign rsp.valid               = out_vld_reg;
    assign rsp.result              = out_item_reg.result;
    assign rsp.result_size         = out_item_reg.result_size;
    assign rsp.writes_result       = out_item_reg.writes_result;
    assign rsp.to_address_register = out_item_reg.to_address_register;
    assign rsp.flags_out           = out_item_reg.flags_out;
    assign rsp.status              = out_item_reg.status;

endmodule

@@ tb/sv/tb_add_sub_compare_alu_with_flags.sv @@
module tb_add_sub_compare_alu_with_flags;
    import asc_pkg::*;

    class alu_scoreboard;
        out_item_t pending_results[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // sized add or subtract with carry in, gives nzvc of the sized value
        function void sized_arith(input logic [DATA_W-1:0] d_in, input logic [DATA_W-1:0] s_in,
                                  input logic x, input logic [SIZE_W-1:0] sz,
                                  input logic sub, output logic [DATA_W-1:0] r,
                                  output nzvc_t f);
            logic [DATA_W-1:0] m;
            logic [DATA_W-1:0] d;
            logic [DATA_W-1:0] s;
            logic [DATA_W-1:0] c;
            logic [DATA_W-1:0] v;
            int top;
            m = (sz == SIZE_BYTE) ? 32'h0000_00FF :
                (sz == SIZE_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
            top = (sz == SIZE_BYTE) ? 7 : (sz == SIZE_WORD) ? 15 : 31;
            d = d_in & m;
            s = s_in & m;
            if (sub)
            begin
                r = (d - s - {31'b0, x}) & m;
                c = (s & ~d) | (r & (~d | s));
                v = (s ^ d) & (r ^ d);
            end
            else
            begin
                r = (d + s + {31'b0, x}) & m;
                c = (s & d) | (~r & (s | d));
                v = (s ^ r) & (d ^ r);
            end
            f.n = r[top];
            f.z = (r == '0);
            f.v = v[top];
            f.c = c[top];
        endfunction

        function out_item_t exec_alu(in_item_t it);
            out_item_t o;
            logic [3:0] grp;
            logic [2:0] opmode;
            logic [2:0] mode;
            logic [SIZE_W-1:0] sz;
            logic sub;
            logic xin;
            logic [DATA_W-1:0] s;
            logic [DATA_W-1:0] r;
            nzvc_t f;
            grp = it.opcode[15:12];
            opmode = it.opcode[8:6];
            sz = it.opcode[7:6];
            mode = it.opcode[5:3];
            sub = (grp == GROUP_SUB);
            xin = it.flags_in[FLAG_X];
            o.result = '0;
            o.result_size = SIZE_BYTE;
            o.writes_result = 1'b0;
            o.to_address_register = 1'b0;
            o.flags_out = it.flags_in;
            o.status = STATUS_DONE;
            if (grp == GROUP_MOVEQ)
            begin
                r = {{24{it.opcode[7]}}, it.opcode[7:0]};
                o.result = r;
                o.result_size = SIZE_LONG;
                o.writes_result = 1'b1;
                o.flags_out = '0;
                o.flags_out[FLAG_X] = xin;
                o.flags_out[FLAG_N] = r[31];
                o.flags_out[FLAG_Z] = (r == '0);
            end
            else if (grp == GROUP_SUB || grp == GROUP_ADD || grp == GROUP_CMP)
            begin
                if (opmode == OPMODE_ADDR_WORD || opmode == OPMODE_ADDR_LONG)
                begin
                    s = (opmode == OPMODE_ADDR_WORD) ?
                        {{16{it.source_value[15]}}, it.source_value[15:0]} : it.source_value;
                    o.result_size = SIZE_LONG;
                    if (grp == GROUP_CMP)
                    begin
                        sized_arith(it.dest_value, s, 1'b0, SIZE_LONG, 1'b1, r, f);
                        o.flags_out = {xin, f};
                    end
                    else
                    begin
                        o.result = sub ? it.dest_value - s : it.dest_value + s;
                        o.writes_result = 1'b1;
                        o.to_address_register = 1'b1;
                    end
                end
                else if (grp == GROUP_CMP && it.opcode[8])
                begin
                    o.result_size = sz;
                    if (mode == MODE_AREG)
                    begin
                        sized_arith(it.dest_value, it.source_value, 1'b0, sz, 1'b1, r, f);
                        o.flags_out = {xin, f};
                    end
                    else
                        o.status = STATUS_UNHANDLED;
                end
                else if (grp != GROUP_CMP && it.opcode[8] && it.opcode[5:4] == 2'b00)
                begin
                    // extended forms
                    sized_arith(it.dest_value, it.source_value, xin, sz, sub, r, f);
                    o.result_size = sz;
                    o.result = r;
                    o.writes_result = 1'b1;
                    o.flags_out = {f.c, f.n, (r == '0) ? it.flags_in[FLAG_Z] : 1'b0, f.v, f.c};
                end
                else
                begin
                    o.result_size = sz;
                    if (sz == SIZE_BYTE && mode == MODE_AREG)
                        o.status = STATUS_ILLEGAL_AN;
                    else if (grp == GROUP_CMP)
                    begin
                        sized_arith(it.dest_value, it.source_value, 1'b0, sz, 1'b1, r, f);
                        o.flags_out = {xin, f};
                    end
                    else
                    begin
                        sized_arith(it.dest_value, it.source_value, 1'b0, sz, sub, r, f);
                        o.result = r;
                        o.writes_result = 1'b1;
                        o.flags_out = {f.c, f};
                    end
                end
            end
            else
                o.status = STATUS_UNHANDLED;
            return o;
        endfunction

        function void note_input(in_item_t it);
            pending_results.push_back(exec_alu(it));
        endfunction

        function void cmp_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            cmp_field("result", want.result, got.result);
            cmp_field("result_size", 32'(want.result_size), 32'(got.result_size));
            cmp_field("writes_result", 32'(want.writes_result), 32'(got.writes_result));
            cmp_field("to_address_register", 32'(want.to_address_register),
                      32'(got.to_address_register));
            cmp_field("flags_out", 32'(want.flags_out), 32'(got.flags_out));
            cmp_field("status", 32'(want.status), 32'(got.status));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic no_idle;
    alu_scoreboard sb;

    asc_in_if  req_ch();
    asc_out_if rsp_ch();

    add_sub_compare_alu_with_flags u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_input({req_ch.opcode, req_ch.source_value, req_ch.dest_value,
                               req_ch.flags_in});
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result({rsp_ch.result, rsp_ch.result_size, rsp_ch.writes_result,
                                 rsp_ch.to_address_register, rsp_ch.flags_out,
                                 rsp_ch.status});
        end
    end

    function automatic logic [OPCODE_W-1:0] opw(logic [3:0] grp, logic [2:0] rx,
                                               logic [2:0] opmode, logic [2:0] mode,
                                               logic [2:0] ry);
        return {grp, rx, opmode, mode, ry};
    endfunction

    function automatic in_item_t mk(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] s,
                                    logic [DATA_W-1:0] d, logic [FLAGS_W-1:0] f);
        in_item_t it;
        it.opcode = op;
        it.source_value = s;
        it.dest_value = d;
        it.flags_in = f;
        return it;
    endfunction

    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 9))
                0: v = 32'h0000_0000;
                1: v = 32'hFFFF_FFFF;
                2: v = 32'h8000_0000;
                3: v = 32'h7FFF_FFFF;
                4: v = 32'h0000_0080;
                5: v = 32'h0000_007F;
                6: v = 32'h0000_00FF;
                7: v = 32'h0000_8000;
                8: v = 32'h0000_7FFF;
                default: v = 32'h0000_FFFF;
            endcase
        end
        return v;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        logic [15:0] word16;
        logic [3:0] grp;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        word16 = 16'($urandom);
        case ($urandom_range(0, 2))
            0: grp = GROUP_SUB;
            1: grp = GROUP_CMP;
            default: grp = GROUP_ADD;
        endcase
        if (pick < 10)
            it.opcode = {GROUP_MOVEQ, word16[11:0]};
        else if (pick < 20)
            it.opcode = word16;
        else
            it.opcode = {grp, word16[11:0]};
        it.source_value = rand_operand();
        it.dest_value = rand_operand();
        it.flags_in = FLAGS_W'($urandom);
        case ($urandom_range(0, 9))
            0: it.dest_value = it.source_value;
            1: it.dest_value = -it.source_value;
            2: it.dest_value = ~it.source_value;
            default: ;
        endcase
        return it;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 7);
    endfunction

    task automatic send_item(in_item_t it);
        while (idle_now())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= it.opcode;
        req_ch.source_value <= it.source_value;
        req_ch.dest_value   <= it.dest_value;
        req_ch.flags_in     <= it.flags_in;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // moveq extremes, bit 8 ignored
        send_item(mk(opw(GROUP_MOVEQ, 3'd0, 3'b000, 3'd0, 3'd0), '0, '0, 5'h1F));
        send_item(mk(16'h707F, 32'hFFFF_FFFF, '0, 5'h00));
        send_item(mk(16'h7180, '0, '0, 5'h00));
        send_item(mk(16'h7EFF, '0, 32'hFFFF_FFFF, 5'h1F));
        // plain add and sub, all sizes
        send_item(mk(opw(GROUP_ADD, 3'd1, 3'b000, 3'd0, 3'd2), 32'h0000_00FF,
                     32'h0000_0001, 5'h00));
        send_item(mk(opw(GROUP_ADD, 3'd1, 3'b001, MODE_AREG, 3'd2), 32'h0000_7FFF,
                     32'h0000_0001, 5'h1F));
        send_item(mk(opw(GROUP_ADD, 3'd7, 3'b010, 3'd7, 3'd7), 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 5'h00));
        send_item(mk(opw(GROUP_SUB, 3'd2, 3'b100, 3'd2, 3'd3), 32'h0000_0001, '0, 5'h00));
        send_item(mk(opw(GROUP_SUB, 3'd2, 3'b110, 3'd5, 3'd3), 32'h0000_0001,
                     32'h8000_0000, 5'h1F));
        // byte access on an address register
        send_item(mk(opw(GROUP_ADD, 3'd0, 3'b000, MODE_AREG, 3'd0), 32'h1234_5678,
                     32'h9ABC_DEF0, 5'h15));
        send_item(mk(opw(GROUP_SUB, 3'd3, 3'b000, MODE_AREG, 3'd4), 32'h1, 32'h2, 5'h0A));
        send_item(mk(opw(GROUP_CMP, 3'd3, 3'b000, MODE_AREG, 3'd4), 32'h1, 32'h2, 5'h0A));
        // compares
        send_item(mk(opw(GROUP_CMP, 3'd0, 3'b000, 3'd0, 3'd1), 32'h0000_0055,
                     32'h0000_0055, 5'h10));
        send_item(mk(opw(GROUP_CMP, 3'd0, 3'b010, 3'd3, 3'd1), 32'h0000_0001, '0, 5'h00));
        send_item(mk(opw(GROUP_CMP, 3'd4, OPMODE_ADDR_WORD, 3'd0, 3'd1), 32'h0000_8000,
                     32'hFFFF_8000, 5'h1F));
        send_item(mk(opw(GROUP_CMP, 3'd4, OPMODE_ADDR_LONG, 3'd0, 3'd1), 32'h8000_0000,
                     32'h7FFF_FFFF, 5'h00));
        // address forms
        send_item(mk(opw(GROUP_ADD, 3'd5, OPMODE_ADDR_WORD, 3'd0, 3'd0), 32'h1234_FFFF,
                     32'h0000_0001, 5'h1F));
        send_item(mk(opw(GROUP_SUB, 3'd5, OPMODE_ADDR_LONG, 3'd2, 3'd0), 32'hFFFF_FFFF,
                     '0, 5'h00));
        // extended forms: z kept on zero, cleared otherwise
        send_item(mk(opw(GROUP_ADD, 3'd1, 3'b100, 3'd0, 3'd2), 32'h0000_00FF, '0, 5'h14));
        send_item(mk(opw(GROUP_ADD, 3'd1, 3'b110, MODE_AREG, 3'd2), 32'h7FFF_FFFF,
                     32'h0000_0000, 5'h14));
        send_item(mk(opw(GROUP_SUB, 3'd1, 3'b101, 3'd0, 3'd2), '0, '0, 5'h10));
        send_item(mk(opw(GROUP_SUB, 3'd1, 3'b100, MODE_AREG, 3'd2), 32'h0000_00AA,
                     32'h0000_00AA, 5'h04));
        // cmpm, eor and foreign groups
        send_item(mk(opw(GROUP_CMP, 3'd1, 3'b101, MODE_AREG, 3'd2), 32'h0000_8001,
                     32'h0000_0001, 5'h10));
        send_item(mk(opw(GROUP_CMP, 3'd1, 3'b110, 3'd0, 3'd2), 32'h1, 32'h2, 5'h0F));
        send_item(mk(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F));
        send_item(mk(16'hFFFF, '0, '0, 5'h00));
    endtask

    initial
    begin
        int i;
        sb = new();
        rst_n = 1'b0;
        no_idle = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.source_value = '0;
        req_ch.dest_value = '0;
        req_ch.flags_in = '0;
        rsp_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (i = 0; i < 1800; i++)
        begin
            no_idle <= (i >= 700 && i < 1100);
            send_item(rand_item());
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected beats never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
